[design/analog_key_ladder_autorepeat_core_assert.svh]
// ---------------------------------------------------------------------------
// Assertion macros for the key ladder decoder
// Concurrent checks that compile to nothing when ASSERT_OFF is defined.
// ---------------------------------------------------------------------------
`ifndef ANALOG_KEY_LADDER_AUTOREPEAT_CORE_ASSERT_SVH
`define ANALOG_KEY_LADDER_AUTOREPEAT_CORE_ASSERT_SVH

`ifndef ASSERT_OFF
`define AKLAR_ASSERT_IMPL(label, clk, rst_n, ante, cons) \
    label: assert property (@(posedge clk) disable iff (!rst_n) (ante) |-> (cons)) \
        else $error("assertion failed");
`define AKLAR_ASSERT_NEXT(label, clk, rst_n, ante, cons) \
    label: assert property (@(posedge clk) disable iff (!rst_n) (ante) |=> (cons)) \
        else $error("assertion failed");
`else
`define AKLAR_ASSERT_IMPL(label, clk, rst_n, ante, cons)
`define AKLAR_ASSERT_NEXT(label, clk, rst_n, ante, cons)
`endif

`endif

[design/aklar_pkg.sv]
// ---------------------------------------------------------------------------
// Key ladder decoder package
// Key codes, level thresholds and register reset values.
// ---------------------------------------------------------------------------
package aklar_pkg;

    typedef enum logic [2:0] {
        KEY_NONE   = 3'd0,
        KEY_RIGHT  = 3'd1,
        KEY_UP     = 3'd2,
        KEY_DOWN   = 3'd3,
        KEY_LEFT   = 3'd4,
        KEY_SELECT = 3'd5,
        KEY_ESCAPE = 3'd6
    } key_t;

    typedef enum logic [2:0] {
        REG_SAMPLE_PERIOD   = 3'd0,
        REG_STABLE_DELTA    = 3'd1,
        REG_FIRST_REPEAT    = 3'd2,
        REG_REPEAT_INTERVAL = 3'd3,
        REG_LONG_PRESS      = 3'd4
    } reg_idx_t;

    localparam int unsigned ADC_BITS_DEFAULT = 10;
    localparam int unsigned LIMIT_REF_BITS   = 10;
    localparam int unsigned NUM_LEVELS       = 5;
    localparam int unsigned LEVEL_LIMITS [NUM_LEVELS] = '{49, 176, 331, 523, 831};

    localparam logic [7:0]  SAMPLE_PERIOD_RST   = 8'd20;
    localparam logic [9:0]  STABLE_DELTA_RST    = 10'd5;
    localparam logic [15:0] FIRST_REPEAT_RST    = 16'd500;
    localparam logic [15:0] REPEAT_INTERVAL_RST = 16'd200;
    localparam logic [15:0] LONG_PRESS_RST      = 16'd3000;

    function automatic logic [15:0] at_least_one(input logic [15:0] v);
        at_least_one = (v == 16'd0) ? 16'd1 : v;
    endfunction

endpackage

[design/analog_key_ladder_autorepeat_core.sv]
// ---------------------------------------------------------------------------
// Analog key ladder decoder with auto-repeat
// Each result is registered in the output register, or in the skid stage.
// Throughput: one sample per cycle while skid is empty; classification and
//   key state update in a single pass between state and output registers.
// A skid stage behind the output register keeps s_tready high through one
//   stalled result. Reset (aresetn, synchronous, active low) restores the
//   config and key state registers to defaults and empties both output stages.
// ---------------------------------------------------------------------------
`include "analog_key_ladder_autorepeat_core_assert.svh"

module analog_key_ladder_autorepeat_core #(
    parameter int unsigned ADC_BITS = aklar_pkg::ADC_BITS_DEFAULT
) (
    input  logic                              aclk,
    input  logic                              aresetn,
    // s_tdata: adc_sample [ADC_BITS-1:0], zero padded
    input  logic                              s_tvalid,
    output logic                              s_tready,
    input  logic [((ADC_BITS + 7) / 8)*8-1:0] s_tdata,
    // m_tdata: key_event [2:0], held_key [5:3], zero [7:6]
    output logic                              m_tvalid,
    input  logic                              m_tready,
    output logic [7:0]                        m_tdata,
    input  logic                              psel,
    input  logic                              penable,
    input  logic                              pwrite,
    input  logic [4:0]                        paddr,
    input  logic [31:0]                       pwdata,
    output logic [31:0]                       prdata,
    output logic                              pready
);
    import aklar_pkg::*;

    localparam int unsigned CMP_W = (ADC_BITS > 10) ? ADC_BITS : 10;

    typedef enum logic [1:0] {
        MODE_IDLE   = 2'd0,
        MODE_ONCE   = 2'd1,
        MODE_REPEAT = 2'd2,
        MODE_SELECT = 2'd3
    } mode_t;

    function automatic logic [ADC_BITS-1:0] scaled_limit(input int unsigned i);
        scaled_limit = ADC_BITS'((LEVEL_LIMITS[i] << ADC_BITS) >> LIMIT_REF_BITS);
    endfunction

    logic [7:0]  sample_period_reg;
    logic [9:0]  stable_delta_reg;
    logic [15:0] first_repeat_reg;
    logic [15:0] repeat_interval_reg;
    logic [15:0] long_press_reg;

    mode_t               mode_reg, mode_next;
    logic [ADC_BITS-1:0] prev_sample_reg, prev_sample_next;
    key_t                stable_key_reg, stable_key_next;
    logic [15:0]         repeat_cnt_reg, repeat_cnt_next;
    logic [7:0]          sample_cnt_reg, sample_cnt_next;
    key_t                event_next;

    logic       out_valid_reg;
    logic [7:0] out_data_reg;
    logic       skid_valid_reg;
    logic [7:0] skid_data_reg;

    logic                s_accept;
    logic                cfg_write;
    reg_idx_t            cfg_idx;
    logic [ADC_BITS-1:0] sample;
    logic [ADC_BITS-1:0] diff;
    key_t                class_key;
    logic                fire;
    logic [7:0]          result;

    assign pready    = 1'b1;
    assign cfg_write = psel && penable && pwrite && pready;
    assign cfg_idx   = reg_idx_t'(paddr[4:2]);

    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            sample_period_reg   <= SAMPLE_PERIOD_RST;
            stable_delta_reg    <= STABLE_DELTA_RST;
            first_repeat_reg    <= FIRST_REPEAT_RST;
            repeat_interval_reg <= REPEAT_INTERVAL_RST;
            long_press_reg      <= LONG_PRESS_RST;
        end else if (cfg_write) begin
            case (cfg_idx)
                REG_SAMPLE_PERIOD:   sample_period_reg   <= pwdata[7:0];
                REG_STABLE_DELTA:    stable_delta_reg    <= pwdata[9:0];
                REG_FIRST_REPEAT:    first_repeat_reg    <= pwdata[15:0];
                REG_REPEAT_INTERVAL: repeat_interval_reg <= pwdata[15:0];
                REG_LONG_PRESS:      long_press_reg      <= pwdata[15:0];
                default: ;
            endcase
        end
    end

    always_comb begin
        case (cfg_idx)
            REG_SAMPLE_PERIOD:   prdata = {24'd0, sample_period_reg};
            REG_STABLE_DELTA:    prdata = {22'd0, stable_delta_reg};
            REG_FIRST_REPEAT:    prdata = {16'd0, first_repeat_reg};
            REG_REPEAT_INTERVAL: prdata = {16'd0, repeat_interval_reg};
            REG_LONG_PRESS:      prdata = {16'd0, long_press_reg};
            default:             prdata = 32'd0;
        endcase
    end

    assign sample   = s_tdata[ADC_BITS-1:0];
    assign s_tready = !skid_valid_reg;
    assign s_accept = s_tvalid && s_tready;

    always_comb begin
        class_key = KEY_NONE;
        for (int i = NUM_LEVELS - 1; i >= 0; i--) begin
            if (sample < scaled_limit(i)) begin
                class_key = key_t'(3'(i + 1));
            end
        end
    end

    always_comb begin
        diff             = (sample >= prev_sample_reg) ? sample - prev_sample_reg
                                                       : prev_sample_reg - sample;
        fire             = (sample_cnt_reg <= 8'd1);
        sample_cnt_next  = fire ? sample_period_reg : sample_cnt_reg - 8'd1;
        prev_sample_next = fire ? sample : prev_sample_reg;
        stable_key_next  = stable_key_reg;
        if (fire && (CMP_W'(diff) < CMP_W'(stable_delta_reg))) begin
            stable_key_next = class_key;
        end

        mode_next       = mode_reg;
        repeat_cnt_next = repeat_cnt_reg;
        event_next      = KEY_NONE;
        case (mode_reg)
            MODE_IDLE: begin
                if (stable_key_next == KEY_LEFT || stable_key_next == KEY_RIGHT) begin
                    event_next = stable_key_next;
                    mode_next  = MODE_ONCE;
                end else if (stable_key_next == KEY_UP || stable_key_next == KEY_DOWN) begin
                    event_next      = stable_key_next;
                    repeat_cnt_next = at_least_one(first_repeat_reg);
                    mode_next       = MODE_REPEAT;
                end else if (stable_key_next == KEY_SELECT) begin
                    repeat_cnt_next = at_least_one(long_press_reg);
                    mode_next       = MODE_SELECT;
                end
            end
            MODE_ONCE: begin
                if (stable_key_next == KEY_NONE) begin
                    mode_next = MODE_IDLE;
                end
            end
            MODE_REPEAT: begin
                if (stable_key_next == KEY_NONE) begin
                    mode_next = MODE_IDLE;
                end else if (repeat_cnt_reg <= 16'd1) begin
                    repeat_cnt_next = at_least_one(repeat_interval_reg);
                    event_next      = stable_key_next;
                end else begin
                    repeat_cnt_next = repeat_cnt_reg - 16'd1;
                end
            end
            MODE_SELECT: begin
                if (stable_key_next == KEY_NONE) begin
                    mode_next  = MODE_IDLE;
                    event_next = KEY_SELECT;
                end else if (repeat_cnt_reg <= 16'd1) begin
                    repeat_cnt_next = 16'd0;
                    event_next      = KEY_ESCAPE;
                    mode_next       = MODE_ONCE;
                end else begin
                    repeat_cnt_next = repeat_cnt_reg - 16'd1;
                end
            end
            default: mode_next = MODE_IDLE;
        endcase
        result = {2'b00, stable_key_next, event_next};
    end

    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            mode_reg        <= MODE_IDLE;
            prev_sample_reg <= {ADC_BITS{1'b1}};
            stable_key_reg  <= KEY_NONE;
            repeat_cnt_reg  <= 16'd0;
            sample_cnt_reg  <= SAMPLE_PERIOD_RST;
        end else if (s_accept) begin
            mode_reg        <= mode_next;
            prev_sample_reg <= prev_sample_next;
            stable_key_reg  <= stable_key_next;
            repeat_cnt_reg  <= repeat_cnt_next;
            sample_cnt_reg  <= sample_cnt_next;
        end
    end

    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            out_valid_reg  <= 1'b0;
            skid_valid_reg <= 1'b0;
        end else begin
            if (!out_valid_reg || m_tready) begin
                if (skid_valid_reg) begin
                    out_valid_reg  <= 1'b1;
                    out_data_reg   <= skid_data_reg;
                    skid_valid_reg <= 1'b0;
                end else begin
                    out_valid_reg <= s_accept;
                    out_data_reg  <= result;
                end
            end else if (s_accept) begin
                skid_valid_reg <= 1'b1;
                skid_data_reg  <= result;
            end
        end
    end

    assign m_tvalid = out_valid_reg;
    assign m_tdata  = out_data_reg;

    `AKLAR_ASSERT_IMPL(a_skid_behind_out, aclk, aresetn, skid_valid_reg, out_valid_reg)
    `AKLAR_ASSERT_NEXT(a_stall_fills_skid, aclk, aresetn,
        s_accept && out_valid_reg && !m_tready, skid_valid_reg)
    `AKLAR_ASSERT_IMPL(a_escape_while_held, aclk, aresetn,
        m_tvalid && m_tdata[2:0] == KEY_ESCAPE, m_tdata[5:3] != KEY_NONE)
    `AKLAR_ASSERT_IMPL(a_dir_event_held, aclk, aresetn,
        m_tvalid && (m_tdata[2:0] == KEY_RIGHT || m_tdata[2:0] == KEY_UP ||
        m_tdata[2:0] == KEY_DOWN || m_tdata[2:0] == KEY_LEFT),
        m_tdata[5:3] == m_tdata[2:0])

endmodule
